[rtl/hrlp_pkg.sv]
// Types, constants and helper functions shared by the request line parser.
package hrlp_pkg;

	// Widths fixed by the line format
	localparam int BYTE_W      = 8;
	localparam int URL_LEN_W   = 11;
	localparam int METHOD_W    = 4;
	localparam int STATUS_W    = 2;
	localparam int NUM_METHODS = 13;
	localparam int POS_W       = 3;

	// Longest URL the counter can track
	localparam logic [URL_LEN_W-1:0] URL_LIMIT_MAX = 11'd1024;

	// Characters that steer the parse
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Method names, right-justified, first character in the highest used byte
	localparam logic [55:0] METHOD_NAME [NUM_METHODS] = '{
		"GET", "HEAD", "POST", "PUT", "DELETE", "OPTIONS", "TRACE",
		"PATCH", "MOVE", "COPY", "LINK", "UNLINK", "WRAPPED"
	};
	localparam logic [POS_W-1:0] METHOD_LEN [NUM_METHODS] = '{
		3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd5,
		3'd5, 3'd4, 3'd4, 3'd4, 3'd6, 3'd7
	};
	localparam logic [NUM_METHODS-1:0] ALL_METHODS = '1;
	localparam logic [METHOD_W-1:0] METHOD_UNKNOWN = 4'd13;

	// Version prefix text
	localparam logic [39:0] VERSION_PREFIX = "HTTP/";
	localparam logic [POS_W-1:0] PREFIX_LEN = 3'd5;

	// Summary status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_URL_LONG  = 2'd1,
		ST_BAD_VER   = 2'd2,
		ST_NO_URL_END = 2'd3
	} status_t;

	// Parse phases
	typedef enum logic [2:0] {
		PH_METHOD   = 3'd0,
		PH_URL      = 3'd1,
		PH_PREFIX   = 3'd2,
		PH_MAJOR    = 3'd3,
		PH_MINOR    = 3'd4,
		PH_TAIL_OK  = 3'd5,
		PH_TAIL_BAD = 3'd6
	} phase_t;

	// Per-line parser state
	typedef struct packed {
		phase_t                 phase;
		logic [POS_W-1:0]       method_pos;
		logic [NUM_METHODS-1:0] method_cand;
		logic [URL_LEN_W-1:0]   url_count;
		logic                   url_overflow;
		logic [POS_W-1:0]       prefix_pos;
		logic [BYTE_W-1:0]      major_value;
		logic [BYTE_W-1:0]      minor_value;
	} parse_state_t;

	// One result transaction
	typedef struct packed {
		logic [BYTE_W-1:0]    url_byte;
		logic                 url_valid;
		logic                 line_done;
		logic [METHOD_W-1:0]  method_code;
		logic [BYTE_W-1:0]    version_major;
		logic [BYTE_W-1:0]    version_minor;
		logic                 version_valid;
		logic [URL_LEN_W-1:0] url_length;
		status_t              status;
	} result_t;

	// Character of method idx at position pos (pos below its length)
	function automatic logic [BYTE_W-1:0] method_char(input int idx,
		input logic [POS_W-1:0] pos);
		int sh;
		sh = (int'(METHOD_LEN[idx]) - 1 - int'(pos)) * 8;
		return METHOD_NAME[idx][sh +: 8];
	endfunction

	// Character of the version prefix at position pos (pos below five)
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
		int sh;
		sh = (int'(PREFIX_LEN) - 1 - int'(pos)) * 8;
		return VERSION_PREFIX[sh +: 8];
	endfunction

	// value * 10 + digit, saturating at 255
	function automatic logic [BYTE_W-1:0] add_digit(input logic [BYTE_W-1:0] v,
		input logic [3:0] d);
		logic [11:0] n;
		n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, d};
		return (n > 12'd255) ? 8'd255 : n[7:0];
	endfunction

endpackage

[rtl/hrlp_method.sv]
// Method name matcher: candidate pruning and final method selection.
module hrlp_method (
	input  logic                            upd_en,
	input  logic [hrlp_pkg::BYTE_W-1:0]     in_byte,
	input  logic [hrlp_pkg::POS_W-1:0]      pos,
	input  logic [hrlp_pkg::NUM_METHODS-1:0] cand,
	output logic [hrlp_pkg::POS_W-1:0]      pos_nxt,
	output logic [hrlp_pkg::NUM_METHODS-1:0] cand_nxt,
	output logic [hrlp_pkg::METHOD_W-1:0]   method_code
);
	import hrlp_pkg::*;

	// Drop every name whose character at this position differs
	always_comb begin
		cand_nxt = cand;
		pos_nxt  = pos;
		if (upd_en) begin
			for (int i = 0; i < NUM_METHODS; i++) begin
				if (pos < METHOD_LEN[i] && in_byte != method_char(i, pos))
					cand_nxt[i] = 1'b0;
			end
			if (pos != 3'd7)
				pos_nxt = pos + 3'd1;
		end
	end

	// First surviving name in table order that was fully seen
	always_comb begin
		method_code = METHOD_UNKNOWN;
		for (int i = NUM_METHODS - 1; i >= 0; i--) begin
			if (cand_nxt[i] && METHOD_LEN[i] <= pos_nxt)
				method_code = METHOD_W'(i);
		end
	end

endmodule

[rtl/hrlp_step.sv]
// Per-byte next-state and result logic of the request line parser.
module hrlp_step (
	input  hrlp_pkg::parse_state_t          st,
	input  logic [hrlp_pkg::BYTE_W-1:0]     in_byte,
	input  logic                            last_byte,
	input  logic [hrlp_pkg::URL_LEN_W-1:0]  max_url_length,
	output hrlp_pkg::parse_state_t          st_nxt,
	output hrlp_pkg::result_t               res
);
	import hrlp_pkg::*;

	logic                   eol;
	logic                   line_end;
	logic                   is_space;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [URL_LEN_W-1:0]   url_lim;
	logic                   method_en;
	logic [POS_W-1:0]       mpos_nxt;
	logic [NUM_METHODS-1:0] mcand_nxt;
	logic [METHOD_W-1:0]    method_code;
	parse_state_t           ps;
	logic [BYTE_W-1:0]      url_byte;
	logic                   url_valid;
	logic                   vvalid;
	status_t                status;

	assign eol      = (in_byte == CH_CR) || (in_byte == CH_LF);
	assign line_end = eol || last_byte;
	assign is_space = (in_byte == CH_SPACE);
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign digit    = 4'(in_byte - CH_ZERO);

	// Clamp the URL limit into range
	always_comb begin
		if (max_url_length == '0)
			url_lim = URL_LEN_W'(1);
		else if (max_url_length > URL_LIMIT_MAX)
			url_lim = URL_LIMIT_MAX;
		else
			url_lim = max_url_length;
	end

	assign method_en = !eol && (st.phase == PH_METHOD) && !is_space;

	hrlp_method u_method (
		.upd_en      (method_en),
		.in_byte     (in_byte),
		.pos         (st.method_pos),
		.cand        (st.method_cand),
		.pos_nxt     (mpos_nxt),
		.cand_nxt    (mcand_nxt),
		.method_code (method_code)
	);

	// Parse one byte
	always_comb begin
		ps = st;
		ps.method_pos  = mpos_nxt;
		ps.method_cand = mcand_nxt;
		url_byte  = '0;
		url_valid = 1'b0;
		if (!eol) begin
			unique case (st.phase)
				PH_METHOD: begin
					if (is_space)
						ps.phase = PH_URL;
				end
				PH_URL: begin
					if (is_space) begin
						ps.phase      = PH_PREFIX;
						ps.prefix_pos = '0;
					end else if (st.url_count < url_lim) begin
						url_byte     = in_byte;
						url_valid    = 1'b1;
						ps.url_count = st.url_count + URL_LEN_W'(1);
					end else begin
						ps.url_overflow = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (st.prefix_pos < PREFIX_LEN && in_byte == prefix_char(st.prefix_pos)) begin
						if (st.prefix_pos == PREFIX_LEN - 3'd1) begin
							ps.phase      = PH_MAJOR;
							ps.prefix_pos = '0;
						end else begin
							ps.prefix_pos = st.prefix_pos + 3'd1;
						end
					end else begin
						ps.phase = PH_TAIL_BAD;
					end
				end
				PH_MAJOR: begin
					if (is_digit) begin
						ps.major_value = add_digit(st.major_value, digit);
						ps.prefix_pos  = 3'd1;
					end else if (in_byte == CH_DOT && st.prefix_pos == 3'd1) begin
						ps.phase      = PH_MINOR;
						ps.prefix_pos = '0;
					end else begin
						ps.phase = PH_TAIL_BAD;
					end
				end
				PH_MINOR: begin
					if (is_digit) begin
						ps.minor_value = add_digit(st.minor_value, digit);
						ps.prefix_pos  = 3'd1;
					end else begin
						ps.phase = (st.prefix_pos == 3'd1) ? PH_TAIL_OK : PH_TAIL_BAD;
					end
				end
				PH_TAIL_OK, PH_TAIL_BAD: ;
				default: ;
			endcase
		end
	end

	// Line summary, status priority: too long, no second space, version
	assign vvalid = (ps.phase == PH_TAIL_OK) ||
		(ps.phase == PH_MINOR && ps.prefix_pos == 3'd1);

	always_comb begin
		priority if (ps.url_overflow)
			status = ST_URL_LONG;
		else if (ps.phase == PH_METHOD || ps.phase == PH_URL)
			status = ST_NO_URL_END;
		else if (!vvalid)
			status = ST_BAD_VER;
		else
			status = ST_OK;
	end

	// Merge summary and pick the next state
	always_comb begin
		st_nxt        = ps;
		res           = '0;
		res.url_byte  = url_byte;
		res.url_valid = url_valid;
		res.line_done = line_end;
		if (line_end) begin
			st_nxt.phase        = PH_METHOD;
			st_nxt.method_pos   = '0;
			st_nxt.method_cand  = ALL_METHODS;
			st_nxt.url_count    = '0;
			st_nxt.url_overflow = 1'b0;
			st_nxt.prefix_pos   = '0;
			st_nxt.major_value  = '0;
			st_nxt.minor_value  = '0;
			res.method_code     = method_code;
			res.version_major   = vvalid ? ps.major_value : '0;
			res.version_minor   = vvalid ? ps.minor_value : '0;
			res.version_valid   = vvalid;
			res.url_length      = ps.url_count;
			res.status          = status;
		end
	end

endmodule

[rtl/http_request_line_parser_top.sv]
// An accepted byte goes into the input register, then is parsed into the result register.
// Throughput: one byte per cycle; the input register and the result register
// each stall only when the stage after them is full and not taken.
// The line state is one register set updated as a byte moves into the result stage.
// Reset (arst_n low) clears the line state and both stages; max_url_length resets to 1024.
// Top level of the HTTP request line parser.
module http_request_line_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,      // max_url_length
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // last_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] url_byte, [11:8] method_code, [19:12] version_major,
	// [27:20] version_minor, [28] version_valid, [39:29] url_length,
	// [41:40] status, [47:42] zero
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tuser,   // url_valid
	output logic        m_axis_tlast    // line_done
);
	import hrlp_pkg::*;

	logic [URL_LEN_W-1:0] max_url_length_q;
	parse_state_t         st_q;
	parse_state_t         st_nxt;
	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 last_s1;
	logic                 valid_s2;
	result_t              res_s2;
	result_t              res_nxt;
	logic                 in_fire;
	logic                 adv2;

	assign adv2          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv2;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_url_length_q <= URL_LIMIT_MAX;
		end else if (cfg_we) begin
			max_url_length_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	hrlp_step u_step (
		.st             (st_q),
		.in_byte        (byte_s1),
		.last_byte      (last_s1),
		.max_url_length (max_url_length_q),
		.st_nxt         (st_nxt),
		.res            (res_nxt)
	);

	// Line state, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_METHOD, method_pos: '0, method_cand: ALL_METHODS,
				url_count: '0, url_overflow: 1'b0, prefix_pos: '0,
				major_value: '0, minor_value: '0};
		end else if (adv2) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2)
			res_s2 <= res_nxt;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.url_valid;
	assign m_axis_tlast  = res_s2.line_done;
	assign m_axis_tdata  = {6'd0, res_s2.status, res_s2.url_length, res_s2.version_valid,
		res_s2.version_minor, res_s2.version_major, res_s2.method_code, res_s2.url_byte};

	// A line end transaction leaves the parser at the start of a fresh line
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && res_nxt.line_done) |=>
		(st_q.phase == PH_METHOD && st_q.url_count == '0 && st_q.method_cand == ALL_METHODS))
		else $error("line state not cleared after line end");

	// URL counter never passes the largest limit
	a_url_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.url_count <= URL_LIMIT_MAX)
		else $error("URL counter out of range");

	// Summary fields are zero unless the transaction ends a line
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.line_done) |-> (m_axis_tdata[47:8] == '0))
		else $error("summary fields set without line end");

	// Version numbers stay zero unless the version was recognized
	a_version_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && !res_nxt.version_valid) |=>
		(res_s2.version_major == '0 && res_s2.version_minor == '0))
		else $error("version numbers set without a valid version");

endmodule
